@@ rtl/memory_value_search_filter_macros.svh @@
// Assertion macros shared by the value search filter RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef MEMORY_VALUE_SEARCH_FILTER_MACROS_SVH
`define MEMORY_VALUE_SEARCH_FILTER_MACROS_SVH
`ifndef SYNTHESIS
`define MVSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("value search filter check failed");
`define MVSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("value search filter check failed");
`else
`define MVSF_ASSERT_IMP(lbl, ante, cons)
`define MVSF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/mvsf_pkg.sv @@
`timescale 1ns / 1ps
// Shared codes and types for the value search filter.
// No dependencies; used by mvsf_eval and memory_value_search_filter.
package mvsf_pkg;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_RESTART = 2'd1;
    localparam logic [1:0] FUNC_COMPARE = 2'd2;
    localparam logic [1:0] FUNC_READ    = 2'd3;

    localparam logic [2:0] KIND_EQ = 3'd0;
    localparam logic [2:0] KIND_LT = 3'd1;
    localparam logic [2:0] KIND_LE = 3'd2;
    localparam logic [2:0] KIND_GT = 3'd3;
    localparam logic [2:0] KIND_GE = 3'd4;
    localparam logic [2:0] KIND_NE = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [1:0] MODE_NIBBLE = 2'd0;
    localparam logic [1:0] MODE_BYTE   = 2'd1;
    localparam logic [1:0] MODE_HALF   = 2'd2;

    localparam logic [1:0] CFG_SIZE_MODE = 2'd0;
    localparam logic [1:0] CFG_USE_LAST  = 2'd1;
    localparam logic [1:0] CFG_BANK0     = 2'd2;
    localparam logic [1:0] CFG_BANK1     = 2'd3;

    localparam logic [3:0] NIBBLE_MASK = 4'hf;
    localparam int         NIBBLE_BITS = 4;
    localparam int         BYTE_BITS   = 8;

    typedef struct packed {
        logic [1:0] mode;
        logic       upper;
        logic [2:0] kind;
    } t_eval_ctl;

endpackage

@@ rtl/mvsf_eval.sv @@
`timescale 1ns / 1ps
// Shared evaluation unit: forms a candidate's live value from fetched bytes
// and tests it against a reference. Depends on mvsf_pkg.
module mvsf_eval (
    input  mvsf_pkg::t_eval_ctl i_ctl,
    input  logic [7:0]          i_lo,
    input  logic [7:0]          i_hi,
    input  logic [15:0]         i_ref,
    output logic [15:0]         o_live,
    output logic                o_pass
);

    always_comb begin
        unique case (i_ctl.mode)
            mvsf_pkg::MODE_NIBBLE: begin
                o_live = i_ctl.upper
                    ? 16'(i_lo[mvsf_pkg::BYTE_BITS-1:mvsf_pkg::NIBBLE_BITS])
                    : 16'(i_lo[mvsf_pkg::NIBBLE_BITS-1:0] & mvsf_pkg::NIBBLE_MASK);
            end
            mvsf_pkg::MODE_BYTE: begin
                o_live = 16'(i_lo);
            end
            default: begin
                // Mode three behaves as halfword.
                o_live = {i_hi, i_lo};
            end
        endcase
    end

    always_comb begin
        unique case (i_ctl.kind)
            mvsf_pkg::KIND_EQ: o_pass = (o_live == i_ref);
            mvsf_pkg::KIND_LT: o_pass = (o_live <  i_ref);
            mvsf_pkg::KIND_LE: o_pass = (o_live <= i_ref);
            mvsf_pkg::KIND_GT: o_pass = (o_live >  i_ref);
            mvsf_pkg::KIND_GE: o_pass = (o_live >= i_ref);
            mvsf_pkg::KIND_NE: o_pass = (o_live != i_ref);
            default:           o_pass = 1'b0;
        endcase
    end

endmodule

@@ rtl/memory_value_search_filter.sv @@
`timescale 1ns / 1ps
// Value search filter top level: watched memory copy, candidate list and
// the sequencer around the shared evaluation unit. Depends on mvsf_pkg, mvsf_eval.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   func bank address data compare_kind ...
//  out      from block o_out_valid / i_out_stall status count found cand_*
//  cfg      to block   i_cfg_we                  i_cfg_index i_cfg_data
//
// Write and failed commands go straight to the final state; a read first passes
// through the candidate read states. A restart steps through GEN, M0, M1 and EXEC
// per candidate, adding M2 in halfword mode; a compare uses CRD and CLAT in place of
// GEN, as the watched memory and the candidate memory each have a single read port.
// The candidate list lives in two halves; a compare writes survivors into the
// other half, so no copy pass is needed. Reset clears control state only.
// A stalled result waits in the output register while the next command runs;
// that command then holds in its final state until the register frees.
module memory_value_search_filter #(
    parameter int BANK_BYTES = 8192,
    parameter int NUM_BANKS  = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic        i_bank,
    input  logic [12:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [2:0]  i_compare_kind,
    input  logic [15:0] i_test_value,
    input  logic [13:0] i_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [14:0] o_count,
    output logic        o_found,
    output logic [12:0] o_cand_address,
    output logic        o_cand_upper,
    output logic [15:0] o_cand_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    `include "memory_value_search_filter_macros.svh"

    localparam int AW       = $clog2(BANK_BYTES);
    localparam int CAND_MAX = 2 * BANK_BYTES;
    localparam int IW       = $clog2(CAND_MAX);
    localparam int CW       = IW + 1;
    localparam int MW       = $clog2(NUM_BANKS * BANK_BYTES);
    localparam int EW       = AW + 17;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GEN  = 4'd1;
    localparam logic [3:0] S_CRD  = 4'd2;
    localparam logic [3:0] S_CLAT = 4'd3;
    localparam logic [3:0] S_M0   = 4'd4;
    localparam logic [3:0] S_M1   = 4'd5;
    localparam logic [3:0] S_M2   = 4'd6;
    localparam logic [3:0] S_EXEC = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // Memories.
    logic [7:0]    r_wmem [NUM_BANKS * BANK_BYTES];
    logic [EW-1:0] r_cmem [2 * CAND_MAX];
    logic [7:0]    r_mq;
    logic [EW-1:0] r_cq;

    // Configuration.
    logic [1:0]  r_size_mode;
    logic        r_use_last;
    logic [13:0] r_bank0;
    logic [13:0] r_bank1;

    // Control and datapath registers.
    logic [3:0]    r_state, n_state;
    logic [1:0]    r_func, n_func;
    logic [2:0]    r_kind, n_kind;
    logic [15:0]   r_test, n_test;
    logic [13:0]   r_index, n_index;
    logic          r_active, n_active;
    logic          r_sel, n_sel;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_end, n_end;
    logic [AW-1:0] r_caddr, n_caddr;
    logic          r_cup, n_cup;
    logic [15:0]   r_cval, n_cval;
    logic [7:0]    r_lo, n_lo;
    logic [7:0]    r_hi, n_hi;
    logic [1:0]    r_status, n_status;
    logic          r_found, n_found;
    logic          r_rd_ok, n_rd_ok;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_status, n_o_status;
    logic [14:0]   r_o_count, n_o_count;
    logic          r_o_found, n_o_found;
    logic [12:0]   r_o_caddr, n_o_caddr;
    logic          r_o_cup, n_o_cup;
    logic [15:0]   r_o_cval, n_o_cval;

    // Combinational helpers.
    logic                in_acc;
    logic [31:0]         size_raw;
    logic [31:0]         size_clamp;
    logic [CW-1:0]       restart_end;
    logic                is_half;
    logic [AW-1:0]       gen_addr;
    logic                gen_up;
    logic [31:0]         lo_full;
    logic [31:0]         hi_off;
    logic [MW-1:0]       m_raddr;
    logic                w_we;
    logic [MW-1:0]       w_waddr;
    logic [IW:0]         c_raddr;
    logic                c_we;
    logic [IW:0]         c_waddr;
    logic [EW-1:0]       c_wdata;
    logic [15:0]         ref_val;
    logic [15:0]         live;
    logic                pass;
    logic                last;
    logic [CW-1:0]       surv;
    mvsf_pkg::t_eval_ctl eval_ctl;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_count        = r_o_count;
    assign o_found        = r_o_found;
    assign o_cand_address = r_o_caddr;
    assign o_cand_upper   = r_o_cup;
    assign o_cand_value   = r_o_cval;

    // Bank size of the bank named by the incoming command, clamped to the bank.
    always_comb begin
        if (32'(i_bank) >= 32'(NUM_BANKS)) begin
            size_raw = 32'd0;
        end else if (i_bank) begin
            size_raw = 32'(r_bank1);
        end else begin
            size_raw = 32'(r_bank0);
        end
        size_clamp = (size_raw > 32'(BANK_BYTES)) ? 32'(BANK_BYTES) : size_raw;
    end

    assign is_half = (r_size_mode != mvsf_pkg::MODE_NIBBLE) &&
                     (r_size_mode != mvsf_pkg::MODE_BYTE);

    always_comb begin
        unique case (r_size_mode)
            mvsf_pkg::MODE_NIBBLE: begin
                restart_end = CW'(size_clamp << 1);
                gen_addr    = AW'(r_i >> 1);
                gen_up      = r_i[0];
            end
            mvsf_pkg::MODE_BYTE: begin
                restart_end = CW'(size_clamp);
                gen_addr    = AW'(r_i);
                gen_up      = 1'b0;
            end
            default: begin
                restart_end = CW'(size_clamp >> 1);
                gen_addr    = AW'(r_i << 1);
                gen_up      = 1'b0;
            end
        endcase
    end

    // Byte addresses in the watched memory; the upper halfword byte wraps
    // to the start of the bank at the bank end.
    always_comb begin
        lo_full = (r_active ? 32'(BANK_BYTES) : 32'd0) + 32'(r_caddr);
        hi_off  = 32'(r_caddr) + 32'd1;
        if (hi_off == 32'(BANK_BYTES)) begin
            hi_off = 32'd0;
        end
        if (r_state == S_M1) begin
            m_raddr = MW'((r_active ? 32'(BANK_BYTES) : 32'd0) + hi_off);
        end else begin
            m_raddr = MW'(lo_full);
        end
    end

    assign w_waddr = MW'((i_bank ? 32'(BANK_BYTES) : 32'd0) + 32'(i_address));
    assign c_raddr = (r_func == mvsf_pkg::FUNC_READ) ? {r_sel, IW'(r_index)}
                                                     : {r_sel, IW'(r_i)};

    assign ref_val        = r_use_last ? r_cval : r_test;
    assign eval_ctl.mode  = r_size_mode;
    assign eval_ctl.upper = r_cup;
    assign eval_ctl.kind  = r_kind;

    mvsf_eval u_eval (
        .i_ctl  (eval_ctl),
        .i_lo   (r_lo),
        .i_hi   (r_hi),
        .i_ref  (ref_val),
        .o_live (live),
        .o_pass (pass)
    );

    assign last = ((r_i + CW'(1)) == r_end);
    assign surv = r_n + CW'(pass);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_kind      = r_kind;
        n_test      = r_test;
        n_index     = r_index;
        n_active    = r_active;
        n_sel       = r_sel;
        n_count     = r_count;
        n_i         = r_i;
        n_n         = r_n;
        n_end       = r_end;
        n_caddr     = r_caddr;
        n_cup       = r_cup;
        n_cval      = r_cval;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_status    = r_status;
        n_found     = r_found;
        n_rd_ok     = r_rd_ok;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_count   = r_o_count;
        n_o_found   = r_o_found;
        n_o_caddr   = r_o_caddr;
        n_o_cup     = r_o_cup;
        n_o_cval    = r_o_cval;
        w_we        = 1'b0;
        c_we        = 1'b0;
        c_waddr     = {r_sel, IW'(r_i)};
        c_wdata     = {r_caddr, r_cup, live};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_func;
                    n_kind   = i_compare_kind;
                    n_test   = i_test_value;
                    n_index  = i_index;
                    n_status = mvsf_pkg::ST_OK;
                    n_found  = 1'b0;
                    n_rd_ok  = 1'b0;
                    n_state  = S_FIN;
                    unique case (i_func)
                        mvsf_pkg::FUNC_WRITE: begin
                            w_we = (32'(i_bank) < 32'(NUM_BANKS)) &&
                                   (32'(i_address) < 32'(BANK_BYTES));
                        end
                        mvsf_pkg::FUNC_RESTART: begin
                            if (size_clamp == 32'd0) begin
                                n_status = mvsf_pkg::ST_ABSENT;
                            end else begin
                                n_active = i_bank;
                                n_i      = '0;
                                n_end    = restart_end;
                                if (restart_end == '0) begin
                                    n_count = '0;
                                end else begin
                                    n_state = S_GEN;
                                end
                            end
                        end
                        mvsf_pkg::FUNC_COMPARE: begin
                            if (r_count != '0) begin
                                n_i     = '0;
                                n_n     = '0;
                                n_end   = r_count;
                                n_state = S_CRD;
                            end
                        end
                        default: begin
                            if (32'(i_index) >= 32'(r_count)) begin
                                n_status = mvsf_pkg::ST_RANGE;
                            end else begin
                                n_state = S_CRD;
                            end
                        end
                    endcase
                end
            end
            S_GEN: begin
                n_caddr = gen_addr;
                n_cup   = gen_up;
                n_state = S_M0;
            end
            S_CRD: begin
                n_state = S_CLAT;
            end
            S_CLAT: begin
                n_caddr = r_cq[EW-1:17];
                n_cup   = r_cq[16];
                n_cval  = r_cq[15:0];
                if (r_func == mvsf_pkg::FUNC_READ) begin
                    n_rd_ok = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_state = S_M0;
                end
            end
            S_M0: begin
                n_state = S_M1;
            end
            S_M1: begin
                n_lo    = r_mq;
                n_state = is_half ? S_M2 : S_EXEC;
            end
            S_M2: begin
                n_hi    = r_mq;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_i = r_i + CW'(1);
                if (r_func == mvsf_pkg::FUNC_RESTART) begin
                    c_we = 1'b1;
                    if (last) begin
                        n_count = r_end;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_GEN;
                    end
                end else begin
                    // Survivors go to the other half of the candidate memory.
                    c_we    = pass;
                    c_waddr = {~r_sel, IW'(r_n)};
                    n_n     = surv;
                    if (last) begin
                        if (surv != '0) begin
                            n_sel   = ~r_sel;
                            n_count = surv;
                            n_found = 1'b1;
                        end
                        n_state = S_FIN;
                    end else begin
                        n_state = S_CRD;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_count   = 15'(r_count);
                    n_o_found   = r_found;
                    n_o_caddr   = r_rd_ok ? 13'(r_caddr) : 13'd0;
                    n_o_cup     = r_rd_ok ? r_cup : 1'b0;
                    n_o_cval    = r_rd_ok ? r_cval : 16'd0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_waddr] <= i_data;
        end
        r_mq <= r_wmem[m_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[c_waddr] <= c_wdata;
        end
        r_cq <= r_cmem[c_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_mode <= mvsf_pkg::MODE_HALF;
            r_use_last  <= 1'b1;
            r_bank0     <= '0;
            r_bank1     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mvsf_pkg::CFG_SIZE_MODE: r_size_mode <= i_cfg_data[1:0];
                mvsf_pkg::CFG_USE_LAST:  r_use_last  <= i_cfg_data[0];
                mvsf_pkg::CFG_BANK0:     r_bank0     <= i_cfg_data;
                default:                 r_bank1     <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_sel       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_sel       <= n_sel;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_kind     <= n_kind;
        r_test     <= n_test;
        r_index    <= n_index;
        r_i        <= n_i;
        r_n        <= n_n;
        r_end      <= n_end;
        r_caddr    <= n_caddr;
        r_cup      <= n_cup;
        r_cval     <= n_cval;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rd_ok    <= n_rd_ok;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_found  <= n_o_found;
        r_o_caddr  <= n_o_caddr;
        r_o_cup    <= n_o_cup;
        r_o_cval   <= n_o_cval;
    end

    `MVSF_ASSERT_IMP(a_count_bound, 1'b1, 32'(r_count) <= 32'(CAND_MAX))
    `MVSF_ASSERT_IMP(a_surv_le_seen, (r_state == S_EXEC) && (r_func == mvsf_pkg::FUNC_COMPARE), r_n <= r_i)
    `MVSF_ASSERT_IMP(a_found_ok, r_out_valid && r_o_found, r_o_status == mvsf_pkg::ST_OK)
    `MVSF_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, r_state != S_IDLE)

endmodule
